// ----- rtl/ukpq_pkg.sv -----
`default_nettype none

package ukpq_pkg;

  // Queue size and derived widths
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FILL_W      = 5;

  // Operation codes
  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  // Input item
  typedef struct packed {
    func_t       func;
    logic [15:0] req_key;
    logic [15:0] req_weight;
    logic [7:0]  req_handle;
  } in_item_t;

  // Result item
  typedef struct packed {
    status_t     status;
    logic [15:0] out_key;
    logic [15:0] out_weight;
    logic [7:0]  out_handle;
    logic [FILL_W-1:0] fill_level;
  } out_item_t;

  // One queue slot
  typedef struct packed {
    logic [15:0] key;
    logic [15:0] weight;
    logic [7:0]  handle;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ukpq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic scan_last;
  } ukpq_stat_t;

endpackage

`default_nettype wire

// ----- rtl/unique_key_priority_queue_unit.sv -----
// Sequence: a dequeue, or an enqueue into an empty queue, goes from acceptance straight to
// the commit state, whose result is registered; an enqueue into a non-empty queue first runs
// the key/weight scan, which reads one queued entry per cycle, and then commits.
// Throughput: one item at a time; the next item is taken once busy falls.
// The result strobe lasts one cycle and cannot be stalled.
// Reset (synchronous, active low) empties the queue; entry contents are not cleared.
`default_nettype none

module unique_key_priority_queue_unit
  import ukpq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output logic          out_valid,
  output out_item_t     out_item
);

  ukpq_cmd_t  cmd;
  ukpq_stat_t stat;

  // Sequencer
  ukpq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_item.func),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Queue storage, scan and commit
  ukpq_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  // An accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // Every commit yields exactly one result strobe
  a_commit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit without result strobe");

  a_strobe_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.commit))
    else $error("result strobe without commit");

  // Fill level never exceeds the queue size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.fill_level <= FILL_W'(QUEUE_DEPTH)))
    else $error("fill level beyond queue size");

  // An empty report leaves nothing queued and zero key and handle
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_EMPTY) |->
      (out_item.fill_level == '0 && out_item.out_key == '0 && out_item.out_handle == '0))
    else $error("empty report with non-zero fields");
`endif

endmodule

`default_nettype wire

// ----- rtl/ukpq_ctrl.sv -----
`default_nettype none

module ukpq_ctrl
  import ukpq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire func_t      func,
  input  wire ukpq_stat_t stat,
  output logic            busy,
  output ukpq_cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          // enqueue into a non-empty queue needs the key/weight scan
          if (func == FUNC_ENQ && !stat.cnt_zero) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_COMMIT;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/ukpq_dpath.sv -----
`default_nettype none

module ukpq_dpath
  import ukpq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ukpq_cmd_t cmd,
  input  wire in_item_t  in_item,
  output ukpq_stat_t     stat,
  output logic           out_valid,
  output out_item_t      out_item
);

  entry_t    entries_r [QUEUE_DEPTH];
  entry_t    entries_nxt [QUEUE_DEPTH];
  in_item_t  req_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] pos_r;
  logic      dup_r;
  logic      found_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;
  entry_t    cur;
  entry_t    new_e;

  assign cur   = entries_r[idx_r];
  assign new_e = '{key: req_r.req_key, weight: req_r.req_weight, handle: req_r.req_handle};

  assign stat.cnt_zero  = (count_r == '0);
  assign stat.scan_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  // Request capture and scan over the queued entries, one per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_item;
      idx_r   <= '0;
      dup_r   <= 1'b0;
      found_r <= 1'b0;
      pos_r   <= count_r;
    end else if (cmd.scan) begin
      idx_r <= idx_r + IDX_W'(1);
      if (cur.key == req_r.req_key) begin
        dup_r <= 1'b1;
      end
      // first entry lighter than the new one marks the insertion point
      if (!found_r && (cur.weight < req_r.req_weight)) begin
        found_r <= 1'b1;
        pos_r   <= CNT_W'(idx_r);
      end
    end
  end

  // Commit: insert, remove head, or refuse
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      entries_nxt[j] = entries_r[j];
    end
    if (cmd.commit) begin
      out_valid_nxt      = 1'b1;
      out_nxt.status     = ST_OK;
      out_nxt.out_key    = '0;
      out_nxt.out_weight = '0;
      out_nxt.out_handle = '0;
      if (req_r.func == FUNC_ENQ) begin
        if (dup_r) begin
          out_nxt.status = ST_DUP;
        end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
          out_nxt.status = ST_FULL;
        end else begin
          // entries from the insertion point move one slot back
          for (int j = 0; j < QUEUE_DEPTH; j++) begin
            if (CNT_W'(j) == pos_r) begin
              entries_nxt[j] = new_e;
            end else if (CNT_W'(j) > pos_r) begin
              entries_nxt[j] = entries_r[IDX_W'(j - 1)];
            end
          end
          count_nxt = count_r + CNT_W'(1);
        end
      end else if (count_r == '0) begin
        out_nxt.status = ST_EMPTY;
      end else begin
        out_nxt.out_key    = entries_r[0].key;
        out_nxt.out_weight = entries_r[0].weight;
        out_nxt.out_handle = entries_r[0].handle;
        // every entry moves one slot towards the head
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
          entries_nxt[j] = entries_r[IDX_W'(j + 1)];
        end
        count_nxt = count_r - CNT_W'(1);
      end
      out_nxt.fill_level = FILL_W'(count_nxt);
    end
  end

  // Queue storage, no reset: slots at or above the count are never read
  always_ff @(posedge clk) begin
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      entries_r[j] <= entries_nxt[j];
    end
    out_r <= out_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

// ----- tb/unique_key_priority_queue_unit_test.sv -----
`default_nettype none

module unique_key_priority_queue_unit_test
  import ukpq_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 344;
  localparam int MAX_GAP = 20;

  // Queue contents as the block should hold them, and the results still owed
  class request_queue_scoreboard;
    entry_t slots[QUEUE_DEPTH];
    int unsigned depth_used;
    out_item_t pending_results[$];
    int unsigned error_count;

    // Apply one request to the shadow queue and return the result it owes
    function out_item_t predict_queue_op(in_item_t item);
      out_item_t res;
      bit dup;
      int unsigned pos;
      res = '0;
      res.status = ST_OK;
      if (item.func == FUNC_ENQ) begin
        dup = 1'b0;
        for (int unsigned i = 0; i < depth_used; i++) begin
          if (slots[i].key == item.req_key) dup = 1'b1;
        end
        // duplicate check wins over the full check
        if (dup) begin
          res.status = ST_DUP;
        end else if (depth_used >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // new entry goes behind all entries of equal or greater weight
          pos = 0;
          while (pos < depth_used && slots[pos].weight >= item.req_weight) pos++;
          for (int unsigned j = depth_used; j > pos; j--) slots[j] = slots[j - 1];
          slots[pos] = '{key: item.req_key, weight: item.req_weight,
                         handle: item.req_handle};
          depth_used++;
        end
      end else if (depth_used == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.out_key    = slots[0].key;
        res.out_weight = slots[0].weight;
        res.out_handle = slots[0].handle;
        for (int unsigned j = 1; j < depth_used; j++) slots[j - 1] = slots[j];
        depth_used--;
      end
      res.fill_level = FILL_W'(depth_used);
      return res;
    endfunction

    function void note_input(in_item_t item);
      pending_results.push_back(predict_queue_op(item));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d fill_level %0d", got.status, got.fill_level);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        error_count++;
      end
      if (got.out_key !== want.out_key) begin
        $error("out_key: expected %h, got %h", want.out_key, got.out_key);
        error_count++;
      end
      if (got.out_weight !== want.out_weight) begin
        $error("out_weight: expected %h, got %h", want.out_weight, got.out_weight);
        error_count++;
      end
      if (got.out_handle !== want.out_handle) begin
        $error("out_handle: expected %h, got %h", want.out_handle, got.out_handle);
        error_count++;
      end
      if (got.fill_level !== want.fill_level) begin
        $error("fill_level: expected %0d, got %0d", want.fill_level, got.fill_level);
        error_count++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  request_queue_scoreboard sb;

  unique_key_priority_queue_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Results are checked before the item taken on the same edge is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) sb.check_result(out_item);
      if (start && busy === 1'b0) sb.note_input(in_item);
    end
  end

  // Ends the run if nothing moves in either direction for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && busy === 1'b0) || out_valid === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Present one item, hold it until taken, then idle the sender at random
  task automatic issue(in_item_t item, int unsigned idle_pct);
    int gap;
    in_item <= item;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic enqueue(logic [15:0] key, logic [15:0] weight, logic [7:0] handle);
    in_item_t item;
    item = '{func: FUNC_ENQ, req_key: key, req_weight: weight, req_handle: handle};
    issue(item, 0);
  endtask

  task automatic dequeue();
    in_item_t item;
    item = '{func: FUNC_DEQ, req_key: 16'($urandom), req_weight: 16'($urandom),
             req_handle: 8'($urandom)};
    issue(item, 0);
  endtask

  // Hold off the sender until every owed result has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  // Keys often from a small pool so duplicates are common; weights often tied
  function automatic in_item_t random_request(int unsigned enq_pct);
    in_item_t item;
    item.func = ($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
    item.req_key = ($urandom_range(1) == 0) ? 16'(16'h8000 + $urandom_range(23))
                                            : 16'($urandom);
    case ($urandom_range(2))
      0: item.req_weight = 16'($urandom_range(3) << 14);
      1: item.req_weight = ($urandom_range(1) == 0) ? 16'hFFFF : 16'h0000;
      default: item.req_weight = 16'($urandom);
    endcase
    item.req_handle = 8'($urandom);
    return item;
  endfunction

  initial begin : stimulus
    int unsigned idle_pcts[4];
    int unsigned enq_pcts[4];
    int unsigned enq_pct;
    sb = new();
    idle_pcts = '{0, 67, 0, 35};
    enq_pcts  = '{25, 50, 75, 90};
    enq_pct   = 50;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty dequeue, field extremes, duplicate, weight tie, full queue
    dequeue();
    enqueue(16'h0000, 16'h0000, 8'h00);
    enqueue(16'hFFFF, 16'hFFFF, 8'hFF);
    enqueue(16'h0000, 16'h1234, 8'h11);
    enqueue(16'h0001, 16'hFFFF, 8'h5A);
    for (int i = 0; i < 13; i++) enqueue(16'(16'h0100 + i), 16'($urandom), 8'(i));
    enqueue(16'h0200, 16'h8000, 8'hA5);
    // duplicate key while full: refused as a duplicate
    enqueue(16'h0001, 16'h0000, 8'h3C);
    repeat (5) dequeue();
    wait_drained();

    // Random phases with varying sender idling and enqueue bias
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) enq_pct = enq_pcts[$urandom_range(3)];
        issue(random_request(enq_pct), idle_pcts[ph]);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/ukpq_pkg.sv
rtl/ukpq_ctrl.sv
rtl/ukpq_dpath.sv
rtl/unique_key_priority_queue_unit.sv
tb/unique_key_priority_queue_unit_test.sv
